[rtl/baro_compensate_ema_delta_assert.svh]
// Assertion macros for the barometer compensation checker.
`ifndef BARO_COMPENSATE_EMA_DELTA_ASSERT_SVH
`define BARO_COMPENSATE_EMA_DELTA_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define BARO_EMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define BARO_EMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/baro_ema_pkg.sv]
// Types, widths and helpers for the barometer compensation block.
`timescale 1ns / 1ps

package baro_ema_pkg;

    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int EMA_FRACTION_BITS_DEF = 16;

    // datapath widths, sized to the value ranges
    localparam int DT_W     = 25;
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int TEMP_W   = 19;
    localparam int OFF_W    = 35;
    localparam int SENS_W   = 34;
    localparam int PLO_W    = 41;
    localparam int PPROD_W  = 59;
    localparam int PSUB_W   = 39;
    localparam int P_W      = 24;
    localparam int FILT_W   = 48;
    localparam int EDIFF_W  = 49;
    localparam int ELO_W    = 40;
    localparam int EPROD_W  = 64;

    localparam int SENS_LO_W  = 17;
    localparam int EDIFF_LO_W = 25;

    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 7;
    localparam int SENS_SHIFT  = 8;
    localparam int P_SHIFT1    = 21;
    localparam int P_SHIFT2    = 15;
    localparam int ALPHA_SHIFT = 16;

    localparam logic signed [TEMP_W-1:0]  TEMP_BASE = 19'sd2000;
    localparam logic signed [MUL_B_W-1:0] ALPHA_NUM = 18'sd13107;

    localparam logic signed [EDIFF_W-1:0] SAT_MAX = 49'sd32767;
    localparam logic signed [EDIFF_W-1:0] SAT_MIN = -49'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_SENSITIVITY   = 3'd0,
        REG_PRESSURE_OFFSET        = 3'd1,
        REG_SENSITIVITY_TEMP_COEFF = 3'd2,
        REG_OFFSET_TEMP_COEFF      = 3'd3,
        REG_REFERENCE_TEMPERATURE  = 3'd4,
        REG_TEMPERATURE_SLOPE      = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [RAW_W-1:0] pressure_raw;
        logic [RAW_W-1:0] temperature_raw;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] rel_pressure;
        logic signed [OUT_W-1:0] temperature_centi;
    } result_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_slope;
    } calib_t;

    typedef struct packed {
        logic start;
        logic result_free;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [EDIFF_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX)
            r = OUT_W'(SAT_MAX);
        else if (v < SAT_MIN)
            r = OUT_W'(SAT_MIN);
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

[rtl/baro_ema_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module baro_ema_mul
    import baro_ema_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

[rtl/baro_ema_core.sv]
// Compensation and averaging sequencer around the shared multiplier.
`timescale 1ns / 1ps

module baro_ema_core
    import baro_ema_pkg::*;
#(
    parameter int EMA_FRACTION_BITS = EMA_FRACTION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  core_ctl_t ctl,
    input  sample_t   sample,
    input  calib_t    calib,
    output core_sts_t sts,
    output result_t   result
);

    localparam logic signed [EDIFF_W-1:0] TRUNC_BIAS =
        EDIFF_W'((64'sd1 <<< EMA_FRACTION_BITS) - 64'sd1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEMP_MUL,
        ST_OFF_MUL,
        ST_SENS_MUL,
        ST_SENS_ADD,
        ST_PLO_MUL,
        ST_PHI_MUL,
        ST_PSUM,
        ST_PCALC,
        ST_EDIFF,
        ST_ELO_MUL,
        ST_EHI_MUL,
        ST_ESUM,
        ST_EUPD,
        ST_DELTA,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    logic                       started_reg;
    logic        [RAW_W-1:0]    d1_reg;
    logic signed [DT_W-1:0]     dt_reg;
    logic signed [TEMP_W-1:0]   temp_reg;
    logic signed [OFF_W-1:0]    off_reg;
    logic signed [SENS_W-1:0]   sens_reg;
    logic        [PLO_W-1:0]    plo_reg;
    logic signed [PPROD_W-1:0]  pprod_reg;
    logic signed [P_W-1:0]      p_reg;
    logic signed [P_W-1:0]      ground_reg;
    logic signed [FILT_W-1:0]   filt_reg;
    logic signed [EDIFF_W-1:0]  ediff_reg;
    logic        [ELO_W-1:0]    elo_reg;
    logic signed [EPROD_W-1:0]  eprod_reg;
    logic signed [EDIFF_W-1:0]  dlt_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod_reg;

    logic signed [PSUB_W-1:0]   psub;
    logic signed [P_W-1:0]      p_val;
    logic signed [FILT_W-1:0]   seed_target;
    logic signed [FILT_W-1:0]   p_target;
    logic signed [FILT_W-1:0]   ground_target;
    logic signed [EDIFF_W-1:0]  dlt_adj;
    logic signed [EDIFF_W-1:0]  dlt_q;
    logic                       sample_ok;

    baro_ema_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    // operand select: each product lands in prod_reg for the following state
    always_comb
    begin
        unique case (state_reg)
            ST_TEMP_MUL:
            begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = $signed({2'b00, calib.temperature_slope});
            end
            ST_OFF_MUL:
            begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = $signed({2'b00, calib.offset_temp_coeff});
            end
            ST_SENS_MUL:
            begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = $signed({2'b00, calib.sensitivity_temp_coeff});
            end
            ST_PLO_MUL:
            begin
                mul_a = $signed({2'b00, d1_reg});
                mul_b = $signed({1'b0, sens_reg[SENS_LO_W-1:0]});
            end
            ST_PHI_MUL:
            begin
                mul_a = $signed({2'b00, d1_reg});
                mul_b = MUL_B_W'($signed(sens_reg[SENS_W-1:SENS_LO_W]));
            end
            ST_ELO_MUL:
            begin
                mul_a = $signed({1'b0, ediff_reg[EDIFF_LO_W-1:0]});
                mul_b = ALPHA_NUM;
            end
            ST_EHI_MUL:
            begin
                mul_a = MUL_A_W'($signed(ediff_reg[EDIFF_W-1:EDIFF_LO_W]));
                mul_b = ALPHA_NUM;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sample_ok = (sample.pressure_raw != '0) && (sample.temperature_raw != '0);

    // P = asr(asr(D1*SENS, 21) - OFF, 15)
    assign psub  = PSUB_W'(pprod_reg >>> P_SHIFT1) - PSUB_W'(off_reg);
    assign p_val = psub[PSUB_W-1:P_SHIFT2];

    assign seed_target   = FILT_W'(p_val) <<< EMA_FRACTION_BITS;
    assign p_target      = FILT_W'(p_reg) <<< EMA_FRACTION_BITS;
    assign ground_target = FILT_W'(ground_reg) <<< EMA_FRACTION_BITS;

    // divide by 2^F, rounding toward zero
    assign dlt_adj = dlt_reg + (dlt_reg[EDIFF_W-1] ? TRUNC_BIAS : '0);
    assign dlt_q   = dlt_adj >>> EMA_FRACTION_BITS;

    assign result.rel_pressure      = sat16(dlt_q);
    assign result.temperature_centi = sat16(EDIFF_W'(temp_reg));

    assign sts.busy = (state_reg != ST_IDLE);
    assign sts.done = (state_reg == ST_FINISH) && ctl.result_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            d1_reg      <= '0;
            dt_reg      <= '0;
            temp_reg    <= '0;
            off_reg     <= '0;
            sens_reg    <= '0;
            plo_reg     <= '0;
            pprod_reg   <= '0;
            p_reg       <= '0;
            ground_reg  <= '0;
            filt_reg    <= '0;
            ediff_reg   <= '0;
            elo_reg     <= '0;
            eprod_reg   <= '0;
            dlt_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    // a failed read is dropped here and leaves all state alone
                    if (ctl.start && sample_ok)
                    begin
                        d1_reg    <= sample.pressure_raw;
                        dt_reg    <= $signed({1'b0, sample.temperature_raw})
                                   - $signed({1'b0, calib.reference_temperature, 8'h00});
                        state_reg <= ST_TEMP_MUL;
                    end
                end
                ST_TEMP_MUL:
                    state_reg <= ST_OFF_MUL;
                ST_OFF_MUL:
                begin
                    temp_reg  <= TEMP_BASE
                               + $signed(prod_reg[TEMP_SHIFT+TEMP_W-1:TEMP_SHIFT]);
                    state_reg <= ST_SENS_MUL;
                end
                ST_SENS_MUL:
                begin
                    off_reg   <= $signed({3'b000, calib.pressure_offset, 16'h0000})
                               + $signed(prod_reg[OFF_SHIFT+OFF_W-1:OFF_SHIFT]);
                    state_reg <= ST_SENS_ADD;
                end
                ST_SENS_ADD:
                begin
                    sens_reg  <= $signed({3'b000, calib.pressure_sensitivity, 15'h0000})
                               + $signed(prod_reg[SENS_SHIFT+SENS_W-1:SENS_SHIFT]);
                    state_reg <= ST_PLO_MUL;
                end
                ST_PLO_MUL:
                    state_reg <= ST_PHI_MUL;
                ST_PHI_MUL:
                begin
                    plo_reg   <= prod_reg[PLO_W-1:0];
                    state_reg <= ST_PSUM;
                end
                ST_PSUM:
                begin
                    // high partial product weighs 2^17
                    pprod_reg <= $signed({prod_reg[PPROD_W-SENS_LO_W-1:0],
                                          {SENS_LO_W{1'b0}}})
                               + $signed({{(PPROD_W-PLO_W){1'b0}}, plo_reg});
                    state_reg <= ST_PCALC;
                end
                ST_PCALC:
                begin
                    p_reg <= p_val;
                    if (!started_reg)
                    begin
                        ground_reg  <= p_val;
                        filt_reg    <= seed_target;
                        started_reg <= 1'b1;
                        state_reg   <= ST_DELTA;
                    end
                    else
                        state_reg <= ST_EDIFF;
                end
                ST_EDIFF:
                begin
                    // filt + asr(alpha*(target - filt), 16) equals the weighted sum
                    ediff_reg <= EDIFF_W'(p_target) - EDIFF_W'(filt_reg);
                    state_reg <= ST_ELO_MUL;
                end
                ST_ELO_MUL:
                    state_reg <= ST_EHI_MUL;
                ST_EHI_MUL:
                begin
                    elo_reg   <= prod_reg[ELO_W-1:0];
                    state_reg <= ST_ESUM;
                end
                ST_ESUM:
                begin
                    eprod_reg <= $signed({prod_reg[EPROD_W-EDIFF_LO_W-1:0],
                                          {EDIFF_LO_W{1'b0}}})
                               + $signed({{(EPROD_W-ELO_W){1'b0}}, elo_reg});
                    state_reg <= ST_EUPD;
                end
                ST_EUPD:
                begin
                    filt_reg  <= filt_reg
                               + $signed(eprod_reg[ALPHA_SHIFT+FILT_W-1:ALPHA_SHIFT]);
                    state_reg <= ST_DELTA;
                end
                ST_DELTA:
                begin
                    dlt_reg   <= EDIFF_W'(filt_reg) - EDIFF_W'(ground_target);
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (ctl.result_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/baro_compensate_ema_delta.sv]
// Barometer compensation with ground-referenced averaged pressure: top level.
// A valid sample gives its word once the sequencer is through; the first, seeding one skips the update.
// The next sample is taken once the sequencer is idle again; a dropped one leaves it idle.
// Seven products per sample (five for the seeding one) share one 26x18 multiplier.
// The result register lets a new sample enter while the previous word waits.
// Reset clears calibration to zero, unseeds the filter and empties the result register.
`timescale 1ns / 1ps

module baro_compensate_ema_delta
    import baro_ema_pkg::*;
#(
    parameter int EMA_FRACTION_BITS = EMA_FRACTION_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,

    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    calib_t    calib_reg;
    result_t   result_reg;
    logic      result_valid_reg;
    core_ctl_t core_ctl;
    core_sts_t core_sts;
    result_t   core_result;

    assign cfg_ready    = 1'b1;
    assign sample_stall = core_sts.busy;

    assign core_ctl.start       = sample_valid && !core_sts.busy;
    assign core_ctl.result_free = !result_valid_reg || !result_stall;

    baro_ema_core #(
        .EMA_FRACTION_BITS (EMA_FRACTION_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (core_ctl),
        .sample (sample),
        .calib  (calib_reg),
        .sts    (core_sts),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            calib_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PRESSURE_SENSITIVITY:   calib_reg.pressure_sensitivity   <= cfg_data;
                REG_PRESSURE_OFFSET:        calib_reg.pressure_offset        <= cfg_data;
                REG_SENSITIVITY_TEMP_COEFF: calib_reg.sensitivity_temp_coeff <= cfg_data;
                REG_OFFSET_TEMP_COEFF:      calib_reg.offset_temp_coeff      <= cfg_data;
                REG_REFERENCE_TEMPERATURE:  calib_reg.reference_temperature  <= cfg_data;
                REG_TEMPERATURE_SLOPE:      calib_reg.temperature_slope      <= cfg_data;
                default:                    calib_reg <= calib_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else if (core_sts.done)
        begin
            result_valid_reg <= 1'b1;
            result_reg       <= core_result;
        end
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/baro_ema_chk.sv]
// Port-level checker for the barometer compensation block, with its bind.
`timescale 1ns / 1ps
`include "baro_compensate_ema_delta_assert.svh"

module baro_ema_chk
    import baro_ema_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_stall,
    input sample_t sample,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    logic sample_take;
    logic sample_good;

    assign sample_take = sample_valid && !sample_stall;
    assign sample_good = (sample.pressure_raw != '0) && (sample.temperature_raw != '0);

    // a good sample keeps the block busy while the sequencer runs
    `BARO_EMA_ASSERT_NEXT(a_good_goes_busy, sample_take && sample_good, sample_stall, "good sample did not start work")

    // a failed read is dropped at once
    `BARO_EMA_ASSERT_NEXT(a_bad_dropped, sample_take && !sample_good, !sample_stall, "failed read was not dropped")

    // a new word only comes out of a running sequence
    `BARO_EMA_ASSERT_SAME(a_word_from_work, $rose(result_valid), $past(sample_stall), "word without work")

    `BARO_EMA_ASSERT_NEXT(a_word_holds, result_valid && result_stall, result_valid && $stable(result), "stalled word changed")

endmodule

bind baro_compensate_ema_delta baro_ema_chk u_chk (.*);

[sim/baro_compensate_ema_delta_tb.sv]
// Testbench for the barometer compensation block: calibration, drop rules, averaging.
`timescale 1ns / 1ps

module baro_compensate_ema_delta_tb;
    import baro_ema_pkg::*;

    localparam int FRAC_BITS       = EMA_FRACTION_BITS_DEF;
    localparam int NUM_CAL_REGS    = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 20;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;

    localparam longint EMA_WEIGHT_NEW = 13107;
    localparam longint EMA_WEIGHT_OLD = 65536 - 13107;
    localparam longint INT16_MAX      = 32767;
    localparam longint INT16_MIN      = -32768;

    // typical factory calibration; C1..C6 in field order
    localparam calib_t NOMINAL_CALIB = {16'd40127, 16'd36924, 16'd23317,
                                        16'd23282, 16'd33464, 16'd28312};
    localparam int NOMINAL_SPREAD = 2000;

    // with nominal calibration, pressure_raw near this point compensates to about 0 Pa
    localparam logic [RAW_W-1:0] PRESSURE_RAW_ZERO_PA = 24'd3860000;
    localparam logic [RAW_W-1:0] PRESSURE_RAW_SPREAD  = 24'd1500000;
    localparam logic [RAW_W-1:0] TEMP_RAW_NOMINAL     = 24'd8569150;
    localparam logic [RAW_W-1:0] TEMP_RAW_SPREAD      = 24'd1000000;

    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [RAW_W-1:0] RAW_MIN = 24'd1;

    typedef enum int {
        CAL_NEAR_NOMINAL,
        CAL_RANDOM,
        CAL_CORNERS
    } cal_style_e;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample       = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CAL_W-1:0]     cfg_data     = '0;

    // predictor state
    calib_t  calib       = '0;
    longint  ema_q       = 0;
    longint  ground_pa   = 0;
    bit      ema_seeded  = 1'b0;
    int      results_predicted = 0;

    result_t pending_results[$];
    int      failures    = 0;
    int      burst_left  = 0;
    int      idle_cycles = 0;
    int      cycle_count = 0;
    int      stall_mode  = 0;

    baro_compensate_ema_delta DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [OUT_W-1:0] clamp_int16(input longint v);
        if (v > INT16_MAX)
            return OUT_W'(INT16_MAX);
        if (v < INT16_MIN)
            return OUT_W'(INT16_MIN);
        return OUT_W'(v);
    endfunction

    // First-order compensation plus ground-referenced average; 0 when the sample is dropped.
    function automatic bit compensate_sample(input logic [RAW_W-1:0] p_raw,
                                             input logic [RAW_W-1:0] t_raw,
                                             output result_t r);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp_centi, off, sens, pa, target, diff, delta;
        d1 = p_raw;
        d2 = t_raw;
        c1 = calib.pressure_sensitivity;
        c2 = calib.pressure_offset;
        c3 = calib.sensitivity_temp_coeff;
        c4 = calib.offset_temp_coeff;
        c5 = calib.reference_temperature;
        c6 = calib.temperature_slope;
        r  = '0;
        if (d1 == 0 || d2 == 0)
            return 1'b0;

        dt         = d2 - c5 * 256;
        temp_centi = 2000 + ((dt * c6) >>> TEMP_SHIFT);
        off        = c2 * 65536 + ((c4 * dt) >>> OFF_SHIFT);
        sens       = c1 * 32768 + ((c3 * dt) >>> SENS_SHIFT);
        pa         = (((d1 * sens) >>> P_SHIFT1) - off) >>> P_SHIFT2;
        target     = pa <<< FRAC_BITS;

        if (!ema_seeded)
        begin
            ground_pa  = pa;
            ema_q      = target;
            ema_seeded = 1'b1;
        end
        else
        begin
            ema_q = (EMA_WEIGHT_NEW * target + EMA_WEIGHT_OLD * ema_q) >>> ALPHA_SHIFT;
        end

        // delta rounds toward zero, unlike the floor shifts above
        diff = ema_q - (ground_pa <<< FRAC_BITS);
        if (diff < 0)
            delta = -((-diff) >> FRAC_BITS);
        else
            delta = diff >> FRAC_BITS;

        r.rel_pressure      = clamp_int16(delta);
        r.temperature_centi = clamp_int16(temp_centi);
        results_predicted++;
        return 1'b1;
    endfunction

    // Called on a clock edge; returns on the edge where the sample is taken, or after a random gap with valid low.
    task automatic send_sample(input logic [RAW_W-1:0] p_raw, input logic [RAW_W-1:0] t_raw);
        result_t r;
        int      gap;
        sample_valid <= 1'b1;
        sample       <= '{pressure_raw: p_raw, temperature_raw: t_raw};
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        if (compensate_sample(p_raw, t_raw, r))
            pending_results.push_back(r);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 20);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // Drop valid, let every expected word come out, then let the block settle.
    task automatic wait_quiet();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PRESSURE_SENSITIVITY:   calib.pressure_sensitivity   = data;
            REG_PRESSURE_OFFSET:        calib.pressure_offset        = data;
            REG_SENSITIVITY_TEMP_COEFF: calib.sensitivity_temp_coeff = data;
            REG_OFFSET_TEMP_COEFF:      calib.offset_temp_coeff      = data;
            REG_REFERENCE_TEMPERATURE:  calib.reference_temperature  = data;
            REG_TEMPERATURE_SLOPE:      calib.temperature_slope      = data;
            default: ; // unused index, block ignores it
        endcase
    endtask

    task automatic load_calibration(input calib_t c);
        wait_quiet();
        write_reg(REG_PRESSURE_SENSITIVITY,   c.pressure_sensitivity);
        write_reg(REG_PRESSURE_OFFSET,        c.pressure_offset);
        write_reg(REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
        write_reg(REG_OFFSET_TEMP_COEFF,      c.offset_temp_coeff);
        write_reg(REG_REFERENCE_TEMPERATURE,  c.reference_temperature);
        write_reg(REG_TEMPERATURE_SLOPE,      c.temperature_slope);
        cfg_valid <= 1'b0;
    endtask

    function automatic calib_t random_calibration(input cal_style_e style);
        calib_t c;
        c = NOMINAL_CALIB;
        for (int i = 0; i < NUM_CAL_REGS; i++)
        begin
            case (style)
                CAL_RANDOM:
                    c[i*CAL_W +: CAL_W] = CAL_W'($urandom);
                CAL_CORNERS:
                    c[i*CAL_W +: CAL_W] = $urandom_range(0, 1) ? '1 : '0;
                default:
                    c[i*CAL_W +: CAL_W] = CAL_W'(NOMINAL_CALIB[i*CAL_W +: CAL_W]
                                                 + $urandom_range(0, 2 * NOMINAL_SPREAD)
                                                 - NOMINAL_SPREAD);
            endcase
        end
        return c;
    endfunction

    // Reset calibration is all zero: pressure compensates to 0, temperature to 2000.
    task automatic test_reset_calibration();
        send_sample('0, TEMP_RAW_NOMINAL);
        send_sample(PRESSURE_RAW_ZERO_PA, '0);
        send_sample('0, '0);
        // first good sample seeds the average and sets ground
        send_sample(PRESSURE_RAW_ZERO_PA, TEMP_RAW_NOMINAL);
        send_sample(RAW_MAX, RAW_MAX);
    endtask

    task automatic test_nominal_calibration();
        load_calibration(NOMINAL_CALIB);
        send_sample(PRESSURE_RAW_ZERO_PA, TEMP_RAW_NOMINAL);
        send_sample(RAW_MAX, TEMP_RAW_NOMINAL);
        send_sample(RAW_MIN, TEMP_RAW_NOMINAL);
        send_sample(RAW_MIN, TEMP_RAW_NOMINAL);
        send_sample(PRESSURE_RAW_ZERO_PA, RAW_MIN);
        send_sample(PRESSURE_RAW_ZERO_PA, RAW_MAX);
        // dropped after seeding: state must not move
        send_sample('0, TEMP_RAW_NOMINAL);
        send_sample(PRESSURE_RAW_ZERO_PA, '0);
        send_sample(PRESSURE_RAW_ZERO_PA, TEMP_RAW_NOMINAL);
    endtask

    task automatic test_calibration_extremes();
        load_calibration('1);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_MIN, RAW_MIN);
        send_sample(PRESSURE_RAW_ZERO_PA, TEMP_RAW_NOMINAL);
        load_calibration('0);
        send_sample(RAW_MAX, RAW_MIN);
    endtask

    task automatic test_unused_index();
        load_calibration(NOMINAL_CALIB);
        for (int i = NUM_CAL_REGS; i < 2**CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), '1);
        cfg_valid <= 1'b0;
        send_sample(PRESSURE_RAW_ZERO_PA, TEMP_RAW_NOMINAL);
        send_sample(PRESSURE_RAW_ZERO_PA + PRESSURE_RAW_SPREAD, TEMP_RAW_NOMINAL);
    endtask

    task automatic test_random_stream();
        cal_style_e       style;
        int               start;
        int               pick;
        logic [RAW_W-1:0] p_raw;
        logic [RAW_W-1:0] t_raw;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            style = (phase == 2) ? CAL_RANDOM : (phase == 5) ? CAL_CORNERS : CAL_NEAR_NOMINAL;
            load_calibration(random_calibration(style));
            write_reg(CFG_IDX_W'($urandom_range(NUM_CAL_REGS, 2**CFG_IDX_W - 1)),
                      CAL_W'($urandom));
            cfg_valid <= 1'b0;
            start = results_predicted;
            while (results_predicted - start < ITEMS_PER_PHASE)
            begin
                pick  = $urandom_range(0, 99);
                p_raw = RAW_W'(PRESSURE_RAW_ZERO_PA - PRESSURE_RAW_SPREAD
                               + $urandom_range(0, 2 * PRESSURE_RAW_SPREAD));
                t_raw = RAW_W'(TEMP_RAW_NOMINAL - TEMP_RAW_SPREAD
                               + $urandom_range(0, 2 * TEMP_RAW_SPREAD));
                if (pick < 8)
                begin
                    p_raw = RAW_W'($urandom);
                    t_raw = RAW_W'($urandom);
                end
                else if (pick < 12)
                    p_raw = '0;
                else if (pick < 15)
                    t_raw = '0;
                else if (pick < 16)
                begin
                    p_raw = '0;
                    t_raw = '0;
                end
                send_sample(p_raw, t_raw);
            end
        end
    endtask

    // result check and receiver stall pattern
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected: %h", result);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.rel_pressure !== want.rel_pressure)
                    begin
                        $error("rel_pressure: expected %0d, got %0d",
                               want.rel_pressure, result.rel_pressure);
                        failures++;
                    end
                    if (result.temperature_centi !== want.temperature_centi)
                    begin
                        $error("temperature_centi: expected %0d, got %0d",
                               want.temperature_centi, result.temperature_centi);
                        failures++;
                    end
                end
            end
            if (cycle_count % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= (cycle_count % 32 < 16);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_calibration();
        test_nominal_calibration();
        test_calibration_extremes();
        test_unused_index();
        test_random_stream();
        wait_quiet();
        if (failures == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/baro_ema_pkg.sv
rtl/baro_ema_mul.sv
rtl/baro_ema_core.sv
rtl/baro_compensate_ema_delta.sv
rtl/baro_ema_chk.sv
sim/baro_compensate_ema_delta_tb.sv
